[rtl/core/e2e5_pkg.sv]
package e2e5_pkg;

    // widths of the header position logic
    localparam int OFF_W       = 12;
    localparam int POS_W       = 13;
    localparam logic [POS_W-1:0] POS_LIMIT = 13'd8191;

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // frame summary queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // register indexes on the apb port
    localparam logic [1:0] REG_HEADER_OFFSET    = 2'd0;
    localparam logic [1:0] REG_DATA_ID          = 2'd1;
    localparam logic [1:0] REG_MAX_COUNTER_STEP = 2'd2;

    // verdict codes
    typedef enum logic [2:0] {
        V_OK         = 3'd0,
        V_REPEATED   = 3'd1,
        V_WRONG_SEQ  = 3'd2,
        V_CRC_ERR    = 3'd3,
        V_TOO_SHORT  = 3'd4
    } verdict_t;

    // what the front hands over at the last byte of a pdu
    typedef struct packed {
        logic        too_short;
        logic [15:0] crc;
        logic [15:0] stored_crc;
        logic [7:0]  counter;
    } frame_sum_t;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/e2e_p05_frame_checker.sv]
// Receive-side end-to-end profile 5 check. PDU bytes enter one per transaction on
// s_axis (tlast on the final byte) at a sustained rate of one byte per clock while
// the queue is not full, a rate set by the front's byte-wide CRC-16/CCITT-FALSE
// update. At the last byte a frame summary goes into a four-entry queue; the back
// part pops it into stage a, finishes the CRC over the data ID, checks the counter
// window and presents the verdict on m_axis. s_axis_tready drops only while four
// summaries wait in the queue behind a stalled m_axis. Registers are written over
// APB (offset 0x0 header_offset, 0x4 data_id, 0x8 max_counter_step) and should be
// changed only while no verdict is pending. No memory clearing follows reset.
module e2e_p05_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pdu_byte
    input  logic        s_axis_tlast,   // end_of_pdu
    // verdict stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] verdict, [10:3] received_counter
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import e2e5_pkg::*;

    logic [11:0] header_offset_reg;
    logic [15:0] data_id_reg;
    logic [7:0]  max_step_reg;
    logic        cfg_wr;

    logic        push;
    frame_sum_t  push_data;
    logic        pop;
    frame_sum_t  pop_data;
    logic        fifo_full;
    logic        fifo_empty;

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_offset_reg <= '0;
            data_id_reg       <= '0;
            max_step_reg      <= 8'd1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_HEADER_OFFSET:    header_offset_reg <= pwdata[11:0];
                REG_DATA_ID:          data_id_reg       <= pwdata[15:0];
                REG_MAX_COUNTER_STEP: max_step_reg      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HEADER_OFFSET:    prdata = {20'd0, header_offset_reg};
            REG_DATA_ID:          prdata = {16'd0, data_id_reg};
            REG_MAX_COUNTER_STEP: prdata = {24'd0, max_step_reg};
            default:              prdata = '0;
        endcase
    end

    // byte intake and header capture
    e2e5_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .header_offset (header_offset_reg),
        .fifo_full     (fifo_full),
        .push          (push),
        .push_data     (push_data)
    );

    // frame summary queue
    e2e5_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    // crc finish and counter verdict
    e2e5_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .fifo_empty       (fifo_empty),
        .pop_data         (pop_data),
        .pop              (pop),
        .data_id          (data_id_reg),
        .max_counter_step (max_step_reg),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata)
    );

    // a summary is never pushed into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn) !(push && fifo_full))
        else $error("frame summary pushed into full queue");

    // verdict code stays within the defined range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= V_TOO_SHORT))
        else $error("undefined verdict code");

    // a too-short verdict carries a zero counter
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tdata[2:0] == V_TOO_SHORT)) |-> (m_axis_tdata[10:3] == 8'd0))
        else $error("too-short verdict with nonzero counter");

    // the back part only pops a non-empty queue
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !fifo_empty)
        else $error("pop from empty queue");

endmodule

[rtl/core/e2e5_front.sv]
module e2e5_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,   // [7:0] pdu_byte
    input  logic                    s_axis_tlast,   // end_of_pdu
    input  logic [11:0]             header_offset,
    input  logic                    fifo_full,
    output logic                    push,
    output e2e5_pkg::frame_sum_t    push_data
);
    import e2e5_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [15:0]      crc_reg;
    logic [15:0]      stored_reg;
    logic [7:0]       cnt_reg;

    logic [POS_W-1:0] off_ext;
    logic             at_crc_lo;
    logic             at_crc_hi;
    logic             at_cnt;
    logic             accept;
    logic [15:0]      crc_next;
    logic [15:0]      stored_next;
    logic [7:0]       cnt_next;
    logic [POS_W-1:0] pos_next;
    logic             too_short;

    assign s_axis_tready = !fifo_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // header position decode
    assign off_ext   = {1'b0, header_offset};
    assign at_crc_lo = (pos_reg == off_ext);
    assign at_crc_hi = (pos_reg == off_ext + POS_W'(1));
    assign at_cnt    = (pos_reg == off_ext + POS_W'(2));
    assign too_short = ({1'b0, pos_reg} < ({2'b00, header_offset} + 14'd2));

    // per-byte state update
    always_comb begin
        crc_next    = crc_reg;
        stored_next = stored_reg;
        cnt_next    = cnt_reg;
        if (at_crc_lo) begin
            stored_next = {stored_reg[15:8], s_axis_tdata};
        end else if (at_crc_hi) begin
            stored_next = {s_axis_tdata, stored_reg[7:0]};
        end else begin
            crc_next = crc_feed(crc_reg, s_axis_tdata);
            if (at_cnt) begin
                cnt_next = s_axis_tdata;
            end
        end
        pos_next = (pos_reg < POS_LIMIT) ? pos_reg + POS_W'(1) : pos_reg;
    end

    // summary goes to the queue on the last byte
    assign push                 = accept && s_axis_tlast;
    assign push_data.too_short  = too_short;
    assign push_data.crc        = crc_next;
    assign push_data.stored_crc = stored_next;
    assign push_data.counter    = cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            crc_reg    <= CRC_INIT;
            stored_reg <= '0;
            cnt_reg    <= '0;
        end else if (accept) begin
            if (s_axis_tlast) begin
                pos_reg    <= '0;
                crc_reg    <= CRC_INIT;
                stored_reg <= '0;
                cnt_reg    <= '0;
            end else begin
                pos_reg    <= pos_next;
                crc_reg    <= crc_next;
                stored_reg <= stored_next;
                cnt_reg    <= cnt_next;
            end
        end
    end

endmodule

[rtl/core/e2e5_fifo.sv]
module e2e5_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  e2e5_pkg::frame_sum_t    push_data,
    input  logic                    pop,
    output e2e5_pkg::frame_sum_t    pop_data,
    output logic                    full,
    output logic                    empty
);
    import e2e5_pkg::*;

    frame_sum_t           entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + FIFO_CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - FIFO_CW'(1);
            end
        end
    end

endmodule

[rtl/core/e2e5_back.sv]
module e2e5_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    fifo_empty,
    input  e2e5_pkg::frame_sum_t    pop_data,
    output logic                    pop,
    input  logic [15:0]             data_id,
    input  logic [7:0]              max_counter_step,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [15:0]             m_axis_tdata    // [2:0] verdict, [10:3] received_counter
);
    import e2e5_pkg::*;

    // stage a: crc after the data id low byte
    logic        a_valid_reg;
    logic        a_short_reg;
    logic [15:0] a_crc_reg;
    logic [15:0] a_stored_reg;
    logic [7:0]  a_cnt_reg;

    // output register
    logic        m_valid_reg;
    verdict_t    m_verdict_reg;
    logic [7:0]  m_cnt_reg;

    // counter history
    logic        hist_valid_reg;
    logic [7:0]  prev_cnt_reg;

    logic        a_adv;
    logic [15:0] crc_final;
    logic [7:0]  delta;
    verdict_t    verdict_next;
    logic [7:0]  rx_next;
    logic        hist_upd;

    assign a_adv = a_valid_reg && (!m_valid_reg || m_axis_tready);
    assign pop   = !fifo_empty && (!a_valid_reg || a_adv);

    // final crc, compare and counter window
    assign crc_final = crc_feed(a_crc_reg, data_id[15:8]);
    assign delta     = a_cnt_reg - prev_cnt_reg;

    always_comb begin
        verdict_next = V_OK;
        rx_next      = a_cnt_reg;
        hist_upd     = 1'b0;
        if (a_short_reg) begin
            verdict_next = V_TOO_SHORT;
            rx_next      = '0;
        end else if (crc_final != a_stored_reg) begin
            verdict_next = V_CRC_ERR;
        end else begin
            hist_upd = 1'b1;
            if (!hist_valid_reg) begin
                verdict_next = V_OK;
            end else if (delta == '0) begin
                verdict_next = V_REPEATED;
            end else if (delta <= max_counter_step) begin
                verdict_next = V_OK;
            end else begin
                verdict_next = V_WRONG_SEQ;
            end
        end
    end

    // stage a and output register payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            a_short_reg  <= pop_data.too_short;
            a_crc_reg    <= crc_feed(pop_data.crc, data_id[7:0]);
            a_stored_reg <= pop_data.stored_crc;
            a_cnt_reg    <= pop_data.counter;
        end
        if (a_adv) begin
            m_verdict_reg <= verdict_next;
            m_cnt_reg     <= rx_next;
        end
    end

    // control and history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            hist_valid_reg <= 1'b0;
            prev_cnt_reg   <= '0;
        end else begin
            if (pop) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (a_adv && hist_upd) begin
                hist_valid_reg <= 1'b1;
                prev_cnt_reg   <= a_cnt_reg;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b00000, m_cnt_reg, m_verdict_reg};

endmodule
